// File: rtl/chacha_pkg.sv
// Package: shared types, constants and round helpers for the ChaCha20 stream cipher.
`default_nettype none
package chacha_pkg;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int NUM_WORDS     = 16;
  localparam int ROUND_W       = 5;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd4;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [31:0] word_t;
  typedef word_t [NUM_WORDS-1:0] state_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FINAL, ST_XOR, ST_OUT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_in;    // capture input item
    logic load;       // load initial state
    logic col_round;  // column round
    logic diag_round; // diagonal round
    logic finalize;   // add back input state
    logic emit;       // form result, advance position
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_block; // position is 0 for the held item
  } dp_stat_t;

  function automatic word_t rotl(word_t v, int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  typedef struct packed { word_t a, b, c, d; } qr_t;

  function automatic qr_t quarter(qr_t q);
    qr_t r;
    r = q;
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
    return r;
  endfunction
endpackage
`default_nettype wire

// File: rtl/chacha20_stream_cipher.sv
// Top level of the ChaCha20 stream cipher (64-bit counter, 64-bit nonce).
//
// Channel  Dir  Handshake              Payload
// in_      in   in_valid/in_ready      message_word[32], byte_count[3], message_start
// out_     out  out_valid/out_ready    cipher_word[32], valid_bytes[3]
// cfg_     in   cfg_valid/cfg_ready    cfg_index[3], cfg_data[64]
//
// Word at block position 0: load, 20 rounds, add-back, xor, then out;
// other words go straight from load to xor and out. The shared round
// unit (four quarter rounds a cycle) sets the block cost.
// Reset is synchronous, active low; clears keys, nonce, counter and position.
// A held result (out_ready low) stalls the block; the next item is taken as
// the result leaves. cfg_ready is always high.
`default_nettype none
module chacha20_stream_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_message_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_cipher_word,
  output logic [2:0]  out_valid_bytes
);
  import chacha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  chacha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  chacha_dp u_dp (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .in_message_word, .in_byte_count, .in_message_start,
    .out_cipher_word, .out_valid_bytes, .cmd, .stat
  );
endmodule
`default_nettype wire

// File: rtl/chacha_ctrl.sv
// Controller state machine for the ChaCha20 stream cipher.
`default_nettype none
module chacha_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  chacha_pkg::dp_stat_t   stat,
  output chacha_pkg::dp_cmd_t    cmd
);
  import chacha_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic last_round;

  assign last_round = (round_r == ROUND_W'(2*DOUBLE_ROUNDS-1));

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD: begin
        round_nxt = '0;
        state_nxt = stat.need_block ? ST_ROUND : ST_XOR;
      end
      ST_ROUND: begin
        round_nxt = round_r + 1'b1;
        if (last_round) state_nxt = ST_FINAL;
      end
      ST_FINAL: state_nxt = ST_XOR;
      ST_XOR:   state_nxt = ST_OUT;
      ST_OUT: if (out_ready) begin
        state_nxt = in_valid ? ST_LOAD : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.take_in  = in_valid;
      end
      ST_LOAD:  cmd.load = stat.need_block;
      ST_ROUND: begin
        cmd.col_round  = ~round_r[0];
        cmd.diag_round = round_r[0];
      end
      ST_FINAL: cmd.finalize = 1'b1;
      ST_XOR:   cmd.emit = 1'b1;
      ST_OUT: begin
        out_valid   = 1'b1;
        in_ready    = out_ready;
        cmd.take_in = out_ready & in_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> round_r < ROUND_W'(2*DOUBLE_ROUNDS))
    else $error("round index overrun");
  a_final_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINAL |-> $past(state_r) == ST_ROUND)
    else $error("finalize without rounds");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> state_r == ST_OUT)
    else $error("result dropped");
endmodule
`default_nettype wire

// File: rtl/chacha_dp.sv
// Datapath for the ChaCha20 stream cipher: key, counter, round state, keystream.
`default_nettype none
module chacha_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [chacha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic [31:0]                   in_message_word,
  input  logic [2:0]                    in_byte_count,
  input  logic                          in_message_start,
  output logic [31:0]                   out_cipher_word,
  output logic [2:0]                    out_valid_bytes,
  input  chacha_pkg::dp_cmd_t           cmd,
  output chacha_pkg::dp_stat_t          stat
);
  import chacha_pkg::*;

  logic [63:0] key_r [4];
  logic [63:0] nonce_r;
  logic [63:0] ctr_r;
  logic [3:0]  pos_r;
  word_t       word_r;
  logic [2:0]  cnt_r;
  state_t      ws_r, init_r, ks_r;
  state_t      init_w, col_w, diag_w;
  logic [31:0] mask;
  logic [2:0]  cnt_sat;

  assign stat.need_block = (pos_r == 4'd0);

  always_comb begin
    init_w[0] = SIGMA0; init_w[1] = SIGMA1; init_w[2] = SIGMA2; init_w[3] = SIGMA3;
    for (int k = 0; k < 4; k++) begin
      init_w[4+2*k] = key_r[k][31:0];
      init_w[5+2*k] = key_r[k][63:32];
    end
    init_w[12] = ctr_r[31:0];
    init_w[13] = ctr_r[63:32];
    init_w[14] = nonce_r[31:0];
    init_w[15] = nonce_r[63:32];
  end

  // four independent quarter rounds per step
  always_comb begin
    qr_t q;
    col_w  = ws_r;
    diag_w = ws_r;
    for (int k = 0; k < 4; k++) begin
      q = quarter(qr_t'{ws_r[k], ws_r[4+k], ws_r[8+k], ws_r[12+k]});
      col_w[k] = q.a; col_w[4+k] = q.b; col_w[8+k] = q.c; col_w[12+k] = q.d;
      q = quarter(qr_t'{ws_r[k], ws_r[4+(k+1)%4], ws_r[8+(k+2)%4], ws_r[12+(k+3)%4]});
      diag_w[k] = q.a; diag_w[4+(k+1)%4] = q.b;
      diag_w[8+(k+2)%4] = q.c; diag_w[12+(k+3)%4] = q.d;
    end
  end

  assign cnt_sat = (cnt_r > 3'd4) ? 3'd4 : cnt_r;
  always_comb begin
    case (cnt_sat)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) key_r[k] <= '0;
      nonce_r <= '0;
      ctr_r   <= '0;
      pos_r   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_KEY0:  key_r[0] <= cfg_data;
          REG_KEY1:  key_r[1] <= cfg_data;
          REG_KEY2:  key_r[2] <= cfg_data;
          REG_KEY3:  key_r[3] <= cfg_data;
          REG_NONCE: nonce_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take_in && in_message_start) begin
        ctr_r <= '0;
        pos_r <= '0;
      end else if (cmd.emit) begin
        pos_r <= pos_r + 4'd1;
        if (pos_r == 4'd15) ctr_r <= ctr_r + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      word_r <= in_message_word;
      cnt_r  <= in_byte_count;
    end
    if (cmd.load) begin
      ws_r   <= init_w;
      init_r <= init_w;
    end else if (cmd.col_round) ws_r <= col_w;
    else if (cmd.diag_round) ws_r <= diag_w;
    if (cmd.finalize)
      for (int k = 0; k < NUM_WORDS; k++) ks_r[k] <= ws_r[k] + init_r[k];
    if (cmd.emit) begin
      out_cipher_word <= (word_r ^ ks_r[pos_r]) & mask;
      out_valid_bytes <= cnt_sat;
    end
  end

  a_load_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> pos_r == 4'd0)
    else $error("block load off position 0");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.col_round, cmd.diag_round, cmd.finalize, cmd.emit}))
    else $error("conflicting datapath commands");
  a_ctr_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && pos_r == 4'd15 && !cmd.take_in |=> ctr_r == $past(ctr_r) + 64'd1)
    else $error("counter did not advance");
endmodule
`default_nettype wire
